// ===== hdl/plls_pkg.sv =====
// Shared constants, widths and controller/datapath interface types for the route length block.
package plls_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 4;

	localparam int X_W     = COORD_BITS;
	localparam int STOP_W  = 20;
	localparam int TOTAL_W = 40;
	localparam int LEN_W   = 29;

	localparam int IN_DATA_W  = ((2 * X_W + STOP_W + 7) / 8) * 8;
	localparam int OUT_USED_W = TOTAL_W + LEN_W + 2 * STOP_W + 1;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int SUM_W  = SQ_W + 1;
	localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int STEP_W = $clog2(ROOT_W);
	localparam int CMP_W  = (ROOT_W > LEN_W) ? ROOT_W : LEN_W;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};

	typedef struct packed {
		logic load;
		logic sq_x;
		logic sq_y;
		logic add;
		logic step;
		logic finish;
		logic emit;
	} plls_cmd_t;

	typedef struct packed {
		logic seg;
		logic last;
	} plls_sts_t;

endpackage

// ===== hdl/plls_datapath.sv =====
// Datapath: differences, squares, bit-serial square root, total and longest-segment registers.
module plls_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  plls_pkg::plls_cmd_t            cmd,
	input  logic [plls_pkg::X_W-1:0]       x_coord,
	input  logic [plls_pkg::X_W-1:0]       y_coord,
	input  logic [plls_pkg::STOP_W-1:0]    stop_number,
	input  logic                           route_last,
	output plls_pkg::plls_sts_t            sts,
	output logic [plls_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int CB = plls_pkg::COORD_BITS;

	// Route state.
	logic [CB-1:0]                   prev_x_q, prev_y_q;
	logic [plls_pkg::STOP_W-1:0]     prev_stop_q;
	logic                            have_prev_q;
	logic [plls_pkg::TOTAL_W-1:0]    total_q;
	logic [plls_pkg::LEN_W-1:0]      best_len_q;
	logic [plls_pkg::STOP_W-1:0]     best_from_q, best_to_q;
	logic                            seen_q;

	// Per-item working registers.
	logic [CB-1:0]                   dx_q, dy_q;
	logic [plls_pkg::SQ_W-1:0]       sqx_q, sqy_q;
	logic [plls_pkg::RAD_W-1:0]      rad_q;
	logic [plls_pkg::REM_W-1:0]      rem_q;
	logic [plls_pkg::ROOT_W-1:0]     root_q;
	logic                            seg_q, last_q;
	logic [plls_pkg::STOP_W-1:0]     from_q, to_q;
	logic [plls_pkg::OUT_DATA_W-1:0] out_q;

	logic [CB-1:0]                   xc, yc;
	logic [plls_pkg::REM_W-1:0]      rem_sh, trial;
	logic [plls_pkg::CMP_W-1:0]      d_ext, dc_ext;
	logic [plls_pkg::LEN_W-1:0]      dc;
	logic [plls_pkg::TOTAL_W:0]      total_sum;
	logic [plls_pkg::TOTAL_W-1:0]    total_nx;
	logic [plls_pkg::LEN_W-1:0]      best_len_nx;
	logic [plls_pkg::STOP_W-1:0]     best_from_nx, best_to_nx;
	logic                            seen_nx;

	assign xc = CB'(x_coord);
	assign yc = CB'(y_coord);

	// One root digit: bring down the next radicand pair and try 4*root+1.
	assign rem_sh = {rem_q[plls_pkg::REM_W-3:0], rad_q[plls_pkg::RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	assign d_ext  = plls_pkg::CMP_W'(root_q);
	assign dc_ext = (d_ext > plls_pkg::CMP_W'(plls_pkg::LEN_MAX)) ?
		plls_pkg::CMP_W'(plls_pkg::LEN_MAX) : d_ext;
	assign dc     = plls_pkg::LEN_W'(dc_ext);

	assign total_sum = {1'b0, total_q} + (plls_pkg::TOTAL_W + 1)'(root_q);

	always_comb begin
		total_nx     = total_q;
		best_len_nx  = best_len_q;
		best_from_nx = best_from_q;
		best_to_nx   = best_to_q;
		seen_nx      = seen_q;
		if (seg_q) begin
			if (!seen_q || (dc > best_len_q)) begin
				best_len_nx  = dc;
				best_from_nx = from_q;
				best_to_nx   = to_q;
			end
			seen_nx = 1'b1;
			if (total_sum >= {1'b0, plls_pkg::TOTAL_MAX}) begin
				total_nx = plls_pkg::TOTAL_MAX;
			end else begin
				total_nx = total_sum[plls_pkg::TOTAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_stop_q <= '0;
			have_prev_q <= 1'b0;
			total_q     <= '0;
			best_len_q  <= '0;
			best_from_q <= '0;
			best_to_q   <= '0;
			seen_q      <= 1'b0;
			seg_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				prev_x_q    <= xc;
				prev_y_q    <= yc;
				prev_stop_q <= stop_number;
				have_prev_q <= 1'b1;
				seg_q       <= have_prev_q;
				last_q      <= route_last;
			end
			if (cmd.finish) begin
				if (last_q) begin
					prev_x_q    <= '0;
					prev_y_q    <= '0;
					prev_stop_q <= '0;
					have_prev_q <= 1'b0;
					total_q     <= '0;
					best_len_q  <= '0;
					best_from_q <= '0;
					best_to_q   <= '0;
					seen_q      <= 1'b0;
				end else begin
					total_q     <= total_nx;
					best_len_q  <= best_len_nx;
					best_from_q <= best_from_nx;
					best_to_q   <= best_to_nx;
					seen_q      <= seen_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q   <= (xc >= prev_x_q) ? (xc - prev_x_q) : (prev_x_q - xc);
			dy_q   <= (yc >= prev_y_q) ? (yc - prev_y_q) : (prev_y_q - yc);
			from_q <= prev_stop_q;
			to_q   <= stop_number;
		end
		if (cmd.sq_x) begin
			sqx_q <= plls_pkg::SQ_W'(dx_q) * plls_pkg::SQ_W'(dx_q);
		end
		if (cmd.sq_y) begin
			sqy_q <= plls_pkg::SQ_W'(dy_q) * plls_pkg::SQ_W'(dy_q);
		end
		if (cmd.add) begin
			// The fraction bits enter as zero pairs below the integer radicand.
			rad_q  <= plls_pkg::RAD_W'(plls_pkg::SUM_W'(sqx_q) + plls_pkg::SUM_W'(sqy_q))
				<< (2 * plls_pkg::FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.step) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[plls_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[plls_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			out_q <= plls_pkg::OUT_DATA_W'({seen_nx, best_to_nx, best_from_nx,
				best_len_nx, total_nx});
		end
	end

	assign sts.seg  = seg_q;
	assign sts.last = last_q;
	assign m_tdata  = out_q;

endmodule

// ===== hdl/plls_ctrl.sv =====
// Controller: sequences accept, squaring, square-root steps, update and result hand-off.
module plls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  plls_pkg::plls_sts_t sts,
	output plls_pkg::plls_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ADD,
		ST_ROOT,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic [plls_pkg::STEP_W-1:0] step_q;
	logic                        m_tvalid_q;
	logic                        slot_free;

	assign slot_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = s_tvalid;
			ST_SQX:  cmd.sq_x = 1'b1;
			ST_SQY:  cmd.sq_y = 1'b1;
			ST_ADD:  cmd.add  = 1'b1;
			ST_ROOT: cmd.step = 1'b1;
			ST_FIN: begin
				// A result waits here until the output register has room.
				cmd.finish = !sts.last || slot_free;
				cmd.emit   = sts.last && slot_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_ADD;
				ST_ADD: begin
					step_q  <= plls_pkg::STEP_W'(plls_pkg::ROOT_W - 1);
					state_q <= sts.seg ? ST_ROOT : ST_FIN;
				end
				ST_ROOT: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

`ifndef SYNTHESIS
	a_step_only_for_segment: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sts.seg)
		else $error("root step issued for an item without a segment");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result emitted over an untaken result");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is in work");

	a_emit_only_when_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (sts.last && cmd.finish))
		else $error("result emitted for an item not marked last");
`endif

endmodule

// ===== hdl/polyline_length_longest_segment.sv =====
// Top level of the route length and longest segment block.
//
// Usage: points of a route enter on the s_ stream, one item per point. Each item
// carries x and y coordinates and a stop number in s_tdata; s_tlast marks the final
// point of a route. For every point after the first of a route the block adds the
// Euclidean distance (4 fraction bits, rounded down) to a saturating total and keeps
// the longest segment and the stops at its ends, the earlier one on a tie.
// On the last point one result item leaves on the m_ stream; then the route clears.
// Steps: an item passes through its acceptance, the two squares and their sum, then
// the bit-serial square root at one root bit per cycle, then an update; the next
// item is accepted only after that update. The first point of a route skips the
// root steps and goes from the sum straight to the update.
// A result appears in m_tdata in the cycle after the update and sits in an output
// register, so the next point is taken while it waits. If a second result is ready
// before the first is taken, the block holds in its update cycle until m_tready.
// Reset (arst_n low) clears the route state and drops m_tvalid.
module polyline_length_longest_segment (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata from bit 0: x_coord[23:0], y_coord[47:24], stop_number[67:48], zero pad
	input  logic [plls_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tlast: route_last
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata from bit 0: total_length[39:0], longest_length[68:40],
	// longest_from_stop[88:69], longest_to_stop[108:89], has_segment[109], zero pad
	output logic [plls_pkg::OUT_DATA_W-1:0] m_tdata
);

	plls_pkg::plls_cmd_t cmd;
	plls_pkg::plls_sts_t sts;

	plls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plls_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.x_coord     (s_tdata[plls_pkg::X_W-1:0]),
		.y_coord     (s_tdata[2*plls_pkg::X_W-1:plls_pkg::X_W]),
		.stop_number (s_tdata[2*plls_pkg::X_W+plls_pkg::STOP_W-1:2*plls_pkg::X_W]),
		.route_last  (s_tlast),
		.sts         (sts),
		.m_tdata     (m_tdata)
	);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the route length and longest segment block.
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic [plls_pkg::X_W-1:0]    x;
		logic [plls_pkg::X_W-1:0]    y;
		logic [plls_pkg::STOP_W-1:0] stop;
		logic                        last;
		bit                          drain;
	} point_t;

	typedef struct {
		logic [plls_pkg::TOTAL_W-1:0] total;
		logic [plls_pkg::LEN_W-1:0]   longest;
		logic [plls_pkg::STOP_W-1:0]  from_stop;
		logic [plls_pkg::STOP_W-1:0]  to_stop;
		logic                         has_seg;
	} summary_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [plls_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                            s_tlast = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [plls_pkg::OUT_DATA_W-1:0] m_tdata;

	point_t      route_points[$];
	summary_t    due_summaries[$];
	point_t      on_bus;
	int unsigned send_gap = 0;
	int unsigned points_sent = 0;
	int unsigned summaries_seen = 0;
	int unsigned ready_hold = 0;
	int unsigned mismatches = 0;
	bit          long_hold_done = 1'b0;

	// Route state as the block should hold it.
	logic [plls_pkg::X_W-1:0]     prev_x = '0;
	logic [plls_pkg::X_W-1:0]     prev_y = '0;
	logic [plls_pkg::STOP_W-1:0]  prev_stop = '0;
	logic                         have_prev = 1'b0;
	logic [plls_pkg::TOTAL_W-1:0] route_total = '0;
	logic [plls_pkg::LEN_W-1:0]   best_len = '0;
	logic [plls_pkg::STOP_W-1:0]  best_from = '0;
	logic [plls_pkg::STOP_W-1:0]  best_to = '0;
	logic                         seen_segment = 1'b0;

	polyline_length_longest_segment i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Largest root r with r*r not above the scaled squared distance, found bit by bit.
	function automatic logic [plls_pkg::ROOT_W-1:0] segment_length(
			input logic [plls_pkg::X_W-1:0] dx, input logic [plls_pkg::X_W-1:0] dy);
		logic [63:0] rad;
		logic [63:0] root;
		logic [63:0] trial;
		rad = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
		rad = rad << (2 * plls_pkg::FRAC_BITS);
		root = '0;
		for (int b = plls_pkg::ROOT_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= rad)
				root = trial;
		end
		return root[plls_pkg::ROOT_W-1:0];
	endfunction

	function automatic void advance_route(input point_t p);
		logic [plls_pkg::X_W-1:0]    dx;
		logic [plls_pkg::X_W-1:0]    dy;
		logic [plls_pkg::ROOT_W-1:0] seg;
		logic [plls_pkg::LEN_W-1:0]  seg_capped;
		summary_t                    done;
		if (have_prev) begin
			dx = (p.x > prev_x) ? p.x - prev_x : prev_x - p.x;
			dy = (p.y > prev_y) ? p.y - prev_y : prev_y - p.y;
			seg = segment_length(dx, dy);
			seg_capped = (64'(seg) > 64'(plls_pkg::LEN_MAX)) ? plls_pkg::LEN_MAX :
				plls_pkg::LEN_W'(seg);
			// Strictly greater, so the earlier segment wins a tie.
			if (!seen_segment || seg_capped > best_len) begin
				best_len = seg_capped;
				best_from = prev_stop;
				best_to = p.stop;
			end
			seen_segment = 1'b1;
			if (64'(seg) >= 64'(plls_pkg::TOTAL_MAX) - 64'(route_total))
				route_total = plls_pkg::TOTAL_MAX;
			else
				route_total = route_total + plls_pkg::TOTAL_W'(seg);
		end
		prev_x = p.x;
		prev_y = p.y;
		prev_stop = p.stop;
		have_prev = 1'b1;
		if (p.last) begin
			done.total = route_total;
			done.longest = best_len;
			done.from_stop = best_from;
			done.to_stop = best_to;
			done.has_seg = seen_segment;
			due_summaries.insert(due_summaries.size(), done);
			prev_x = '0;
			prev_y = '0;
			prev_stop = '0;
			have_prev = 1'b0;
			route_total = '0;
			best_len = '0;
			best_from = '0;
			best_to = '0;
			seen_segment = 1'b0;
		end
	endfunction

	task automatic add_point(input logic [plls_pkg::X_W-1:0] x,
			input logic [plls_pkg::X_W-1:0] y, input logic [plls_pkg::STOP_W-1:0] stop,
			input logic last, input bit drain);
		point_t p;
		p.x = x;
		p.y = y;
		p.stop = stop;
		p.last = last;
		p.drain = drain;
		route_points.insert(route_points.size(), p);
	endtask

	// Mostly short routes; points jump anywhere, creep by a few units, repeat or sit
	// on the coordinate extremes, so zero-length legs and ties come up often.
	task automatic add_random_routes(input int unsigned count, input bit drain_first);
		int unsigned                 placed;
		int unsigned                 len;
		int unsigned                 pick;
		logic [plls_pkg::X_W-1:0]    gx;
		logic [plls_pkg::X_W-1:0]    gy;
		logic [plls_pkg::STOP_W-1:0] stop;
		placed = 0;
		gx = '0;
		gy = '0;
		while (placed < count) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				len = 1;
			else if (pick < 8)
				len = $urandom_range(2, 6);
			else
				len = $urandom_range(7, 16);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 4))
					0, 1: begin
						gx = plls_pkg::X_W'($urandom);
						gy = plls_pkg::X_W'($urandom);
					end
					2: begin
						gx = gx + plls_pkg::X_W'($urandom_range(0, 3));
						gy = gy - plls_pkg::X_W'($urandom_range(0, 3));
					end
					3: ;
					default: begin
						gx = $urandom_range(0, 1) ? {plls_pkg::X_W{1'b1}} : '0;
						gy = $urandom_range(0, 1) ? {plls_pkg::X_W{1'b1}} : '0;
					end
				endcase
				case ($urandom_range(0, 7))
					0: stop = '0;
					1: stop = '1;
					default: stop = plls_pkg::STOP_W'($urandom);
				endcase
				add_point(gx, gy, stop, k == len - 1, drain_first && placed == 0);
				placed++;
			end
		end
	endtask

	function automatic int unsigned pick_send_gap();
		int unsigned r;
		if (points_sent >= 300 && points_sent < 400)
			return 0;
		r = $urandom_range(0, 15);
		if (r < 10)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		if (r < 15)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned pick_ready_hold();
		int unsigned r;
		r = $urandom_range(0, 255);
		if (r < 200)
			return 0;
		if (r < 240)
			return $urandom_range(1, 3);
		if (r < 254)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_points
		logic offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				advance_route(on_bus);
				points_sent++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (route_points.size() != 0 &&
						!(route_points[0].drain && due_summaries.size() != 0)) begin
					on_bus = route_points.pop_front();
					s_tdata <= {{(plls_pkg::IN_DATA_W - 2 * plls_pkg::X_W -
						plls_pkg::STOP_W){1'b0}}, on_bus.stop, on_bus.y, on_bus.x};
					s_tlast <= on_bus.last;
					offer = 1'b1;
					send_gap = pick_send_gap();
				end
			end
			s_tvalid <= offer;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_summaries
		summary_t want;
		if (!arst_n) begin
			summaries_seen = 0;
		end else if (m_tvalid && m_tready) begin
			summaries_seen++;
			if (due_summaries.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time,
					m_tdata);
				mismatches++;
			end else begin
				want = due_summaries.pop_front();
				check_field("total_length", want.total, m_tdata[0 +: plls_pkg::TOTAL_W]);
				check_field("longest_length", want.longest,
					m_tdata[plls_pkg::TOTAL_W +: plls_pkg::LEN_W]);
				check_field("longest_from_stop", want.from_stop,
					m_tdata[plls_pkg::TOTAL_W + plls_pkg::LEN_W +: plls_pkg::STOP_W]);
				check_field("longest_to_stop", want.to_stop,
					m_tdata[plls_pkg::TOTAL_W + plls_pkg::LEN_W + plls_pkg::STOP_W +:
					plls_pkg::STOP_W]);
				check_field("has_segment", want.has_seg,
					m_tdata[plls_pkg::TOTAL_W + plls_pkg::LEN_W + 2 * plls_pkg::STOP_W]);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : pace_ready
		logic        ready_next;
		int unsigned h;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			// One long hold-off so the output register fills and the input stalls.
			if (summaries_seen >= 20 && !long_hold_done) begin
				ready_hold = 600;
				long_hold_done = 1'b1;
			end
			if (ready_hold != 0) begin
				ready_hold--;
				ready_next = 1'b0;
			end else if (summaries_seen >= 60 && summaries_seen < 90) begin
				ready_next = 1'b1;
			end else begin
				h = pick_ready_hold();
				ready_next = (h == 0);
				if (h != 0)
					ready_hold = h - 1;
			end
			m_tready <= ready_next;
		end
	end

	initial begin : run
		logic [plls_pkg::X_W-1:0]    cmax;
		logic [plls_pkg::X_W-1:0]    czero;
		logic [plls_pkg::STOP_W-1:0] smax;
		int unsigned                 total_points;
		cmax = '1;
		czero = '0;
		smax = '1;

		// Single-point route straight after reset.
		add_point(plls_pkg::X_W'(5), plls_pkg::X_W'(7), plls_pkg::STOP_W'(1), 1'b1, 1'b0);
		// Diagonal across the whole coordinate range.
		add_point(czero, czero, plls_pkg::STOP_W'(0), 1'b0, 1'b0);
		add_point(cmax, cmax, smax, 1'b1, 1'b0);
		// Longest leg first, then a shorter full-range leg.
		add_point(cmax, czero, plls_pkg::STOP_W'(3), 1'b0, 1'b0);
		add_point(czero, cmax, plls_pkg::STOP_W'(4), 1'b0, 1'b0);
		add_point(cmax, cmax, plls_pkg::STOP_W'(5), 1'b1, 1'b0);
		// Only zero-length legs: the first one is kept.
		add_point(plls_pkg::X_W'(100), plls_pkg::X_W'(100), plls_pkg::STOP_W'(6), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(100), plls_pkg::X_W'(100), plls_pkg::STOP_W'(7), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(100), plls_pkg::X_W'(100), plls_pkg::STOP_W'(8), 1'b1, 1'b0);
		// Three legs of equal length, then a short one.
		add_point(czero, czero, plls_pkg::STOP_W'(10), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(3), plls_pkg::X_W'(4), plls_pkg::STOP_W'(11), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(6), plls_pkg::X_W'(8), plls_pkg::STOP_W'(12), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(9), plls_pkg::X_W'(12), plls_pkg::STOP_W'(13), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(9), plls_pkg::X_W'(13), plls_pkg::STOP_W'(14), 1'b1, 1'b0);
		// Zero-length first leg replaced by a longer one.
		add_point(plls_pkg::X_W'(50), plls_pkg::X_W'(50), plls_pkg::STOP_W'(20), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(50), plls_pkg::X_W'(50), plls_pkg::STOP_W'(21), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(51), plls_pkg::X_W'(51), plls_pkg::STOP_W'(22), 1'b1, 1'b0);
		// Fractional lengths rounded down; the last leg is longest.
		add_point(plls_pkg::X_W'(1), czero, plls_pkg::STOP_W'(30), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(2), plls_pkg::X_W'(1), plls_pkg::STOP_W'(31), 1'b0, 1'b0);
		add_point(plls_pkg::X_W'(20), plls_pkg::X_W'(30), smax, 1'b1, 1'b0);
		add_point(cmax, czero, smax, 1'b1, 1'b0);

		add_random_routes(250, 1'b1);
		// A long route of full-range legs that builds a large total.
		for (int k = 0; k < 200; k++)
			add_point((k % 2) ? cmax : czero, (k % 2) ? cmax : czero,
				plls_pkg::STOP_W'($urandom), k == 199, k == 0);
		add_random_routes(280, 1'b1);
		total_points = route_points.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (points_sent != total_points)
			@(posedge clk);
		while (due_summaries.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#(10_000_000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
